// ===== sv/atoc_pkg.sv =====
// Shared types and codes for the two-operand ASCII calculator.
package atoc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CHAR_W = 8;

    // Operation codes that the parser hands to the execution unit.
    localparam int unsigned OP_W = 3;
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_BAD = 3'd4;

    // Depth of the job queue between the parser and the execution unit.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_job;

endpackage

// ===== sv/atoc_if.sv =====
// Handshake interfaces for the character requests and the result requests.
interface atoc_char_if;
    import atoc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;
    modport source (output valid, output char_code, output last, input ready);
    modport sink (input valid, input char_code, input last, output ready);
endinterface

interface atoc_result_if;
    import atoc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     status;
    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

// ===== sv/atoc_parser.sv =====
// Front end: parses the character stream into operands and an operation code.
module atoc_parser
    import atoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    atoc_char_if.sink   i_req,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [2:0] PH_FIRST_START  = 3'd0;
    localparam logic [2:0] PH_FIRST_NUM    = 3'd1;
    localparam logic [2:0] PH_OP_WAIT      = 3'd2;
    localparam logic [2:0] PH_SECOND_START = 3'd3;
    localparam logic [2:0] PH_SECOND_NUM   = 3'd4;
    localparam logic [2:0] PH_DONE         = 3'd5;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF_HX = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

    logic [2:0]        r_phase, n_phase;
    logic [DATA_W-1:0] r_first, n_first;
    logic [DATA_W-1:0] r_second, n_second;
    logic [CHAR_W-1:0] r_op_char, n_op_char;
    logic              r_hex, n_hex;
    logic              r_lz, n_lz;

    logic [CHAR_W-1:0] c;
    logic              fire;
    logic              is_space, is_dec, is_lhex, is_uhex, is_x;
    logic              dig_ok, cont_ok;
    logic [3:0]        dig_val;
    logic [DATA_W-1:0] acc_cur, acc_scaled, acc_new;
    logic [CHAR_W-1:0] t_dec, t_lhex, t_uhex;

    assign c       = i_req.char_code;
    assign i_req.ready = !i_full;
    assign fire    = i_req.valid && !i_full;

    always_comb begin
        t_dec    = c - CH_ZERO;
        t_lhex   = c - CH_LA + 8'd10;
        t_uhex   = c - CH_UA + 8'd10;
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_lhex  = (c >= CH_LA) && (c <= CH_LF_HX);
        is_uhex  = (c >= CH_UA) && (c <= CH_UF);
        is_x     = (c == CH_LX) || (c == CH_UX);
        dig_ok   = is_dec || (r_hex && (is_lhex || is_uhex));
        if (is_dec) begin
            dig_val = t_dec[3:0];
        end else if (is_lhex) begin
            dig_val = t_lhex[3:0];
        end else begin
            dig_val = t_uhex[3:0];
        end
        cont_ok = (r_lz && is_x) || dig_ok;

        // Times ten is eight plus two; times sixteen is a shift.
        acc_cur = (r_phase == PH_FIRST_NUM) ? r_first : r_second;
        if (r_hex) begin
            acc_scaled = {acc_cur[DATA_W-5:0], 4'b0};
        end else begin
            acc_scaled = {acc_cur[DATA_W-4:0], 3'b0} + {acc_cur[DATA_W-2:0], 1'b0};
        end
        acc_new = acc_scaled + {{(DATA_W-4){1'b0}}, dig_val};
    end

    always_comb begin
        n_phase   = r_phase;
        n_first   = r_first;
        n_second  = r_second;
        n_op_char = r_op_char;
        n_hex     = r_hex;
        n_lz      = r_lz;

        if (c == CH_NUL) begin
            n_phase = PH_DONE;
        end else begin
            unique case (r_phase)
                PH_FIRST_START: begin
                    n_hex = 1'b0;
                    n_lz  = (c == CH_ZERO);
                    if (is_dec) begin
                        n_first = {{(DATA_W-4){1'b0}}, dig_val};
                        n_phase = PH_FIRST_NUM;
                    end else if (is_space) begin
                        n_phase = PH_OP_WAIT;
                    end else begin
                        n_op_char = c;
                        n_phase   = PH_SECOND_START;
                    end
                end
                PH_FIRST_NUM, PH_SECOND_NUM: begin
                    if (r_lz && is_x) begin
                        n_hex = 1'b1;
                        n_lz  = 1'b0;
                    end else if (dig_ok) begin
                        n_lz = 1'b0;
                        if (r_phase == PH_FIRST_NUM) begin
                            n_first = acc_new;
                        end else begin
                            n_second = acc_new;
                        end
                    end
                    if (!cont_ok) begin
                        if (r_phase == PH_SECOND_NUM) begin
                            n_phase = PH_DONE;
                        end else if (is_space) begin
                            n_phase = PH_OP_WAIT;
                        end else begin
                            n_op_char = c;
                            n_phase   = PH_SECOND_START;
                        end
                    end
                end
                PH_OP_WAIT: begin
                    if (!is_space) begin
                        n_op_char = c;
                        n_phase   = PH_SECOND_START;
                    end
                end
                PH_SECOND_START: begin
                    if (!is_space) begin
                        n_hex = 1'b0;
                        n_lz  = (c == CH_ZERO);
                        if (is_dec) begin
                            n_second = {{(DATA_W-4){1'b0}}, dig_val};
                            n_phase  = PH_SECOND_NUM;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Classify the operator once the expression is complete.
    always_comb begin
        o_job.a = n_first;
        o_job.b = n_second;
        unique case (n_op_char)
            CH_PLUS:  o_job.op = OP_ADD;
            CH_MINUS: o_job.op = OP_SUB;
            CH_STAR:  o_job.op = OP_MUL;
            CH_SLASH: o_job.op = OP_DIV;
            default:  o_job.op = OP_BAD;
        endcase
        o_push = fire && i_req.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_req.last)) begin
            r_phase   <= PH_FIRST_START;
            r_first   <= '0;
            r_second  <= '0;
            r_op_char <= '0;
            r_hex     <= 1'b0;
            r_lz      <= 1'b0;
        end else if (fire) begin
            r_phase   <= n_phase;
            r_first   <= n_first;
            r_second  <= n_second;
            r_op_char <= n_op_char;
            r_hex     <= n_hex;
            r_lz      <= n_lz;
        end
    end

endmodule

// ===== sv/atoc_queue.sv =====
// Small job queue that decouples the parser from the execution unit.
module atoc_queue
    import atoc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/atoc_exec.sv =====
// Back end: carries out one job and holds its result until it is taken.
module atoc_exec
    import atoc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_job           i_job,
    input  logic           i_empty,
    output logic           o_pop,
    atoc_result_if.source  o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;
    localparam int unsigned CNT_W = $clog2(DATA_W);

    logic [1:0]        r_state;
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_a, r_b;
    logic [DATA_W-1:0] r_res;
    logic              r_err;
    logic [DATA_W-1:0] r_rem, r_quo, r_dvs;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_value;
    logic              r_status;

    logic [DATA_W-1:0]   prod;
    logic [DATA_W:0]     trial;
    logic [DATA_W-1:0]   mag_a, mag_b;
    logic                take, load;

    // Quotient after the current division step.
    function automatic logic [DATA_W-1:0] n_quo_bits(input logic borrow,
                                                     input logic [DATA_W-1:0] quo);
        n_quo_bits = {quo[DATA_W-2:0], !borrow};
    endfunction

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.value  = r_value;
    assign o_rsp.status = r_status;
    assign take         = r_ovalid && o_rsp.ready;
    assign load         = (r_state == S_FIN) && (!r_ovalid || o_rsp.ready);

    always_comb begin
        // Only the low word of the product is kept.
        prod  = r_a * r_b;
        mag_a = r_a[DATA_W-1] ? (~r_a + 1'b1) : r_a;
        mag_b = r_b[DATA_W-1] ? (~r_b + 1'b1) : r_b;
        // One restoring step: shift in the next dividend bit and try to subtract.
        trial = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_job.op;
            r_a  <= i_job.a;
            r_b  <= i_job.b;
        end
        if (r_state == S_CALC) begin
            unique case (r_op)
                OP_ADD: begin
                    r_res <= r_a + r_b;
                    r_err <= 1'b0;
                end
                OP_SUB: begin
                    r_res <= r_a - r_b;
                    r_err <= 1'b0;
                end
                OP_MUL: begin
                    r_res <= prod;
                    r_err <= 1'b0;
                end
                OP_DIV: begin
                    r_res <= '0;
                    r_err <= (r_b == '0);
                    r_rem <= '0;
                    r_quo <= mag_a;
                    r_dvs <= mag_b;
                    r_neg <= r_a[DATA_W-1] ^ r_b[DATA_W-1];
                end
                default: begin
                    r_res <= '0;
                    r_err <= 1'b1;
                end
            endcase
        end
        if (r_state == S_DIV) begin
            if (!trial[DATA_W]) begin
                r_rem <= trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                r_res <= r_neg ? (~n_quo_bits(trial[DATA_W], r_quo) + 1'b1)
                               : n_quo_bits(trial[DATA_W], r_quo);
            end
        end
        if (load) begin
            r_value  <= r_err ? '0 : r_res;
            r_status <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if ((r_op == OP_DIV) && (r_b != '0)) begin
                        r_state <= S_DIV;
                        r_cnt   <= CNT_W'(DATA_W - 1);
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (take) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/ascii_two_operand_calculator.sv =====
// Top level of the two-operand ASCII expression calculator.
// The calculator takes an expression as one ASCII byte per request on i_req and
// returns one result request on o_rsp for each byte that carries the last flag.
// The parser accepts a byte in every cycle as long as its four-entry job queue
// has room; it reads a first number in decimal (or hex after 0x/0X), skips
// whitespace, takes one operator character, skips whitespace and reads a second
// number, ignoring anything after it, and a zero byte ends the expression early.
// Each finished expression becomes one job in the queue. The execution unit
// takes one job at a time: add, subtract, multiply and error cases go from the
// queue through the calculate and finish states to the output register, and a
// division also runs a restoring divider, one quotient bit per cycle, so the
// sustained rate of expressions is set by that divider when quotients dominate.
// All arithmetic wraps modulo 2^32; a missing or unknown operator, or division
// by zero, returns status 1 with value 0. A finished result sits in an output
// register while the next job is already being worked on.
module ascii_two_operand_calculator
    import atoc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    atoc_char_if.sink     i_req,
    atoc_result_if.source o_rsp
);

    t_job job_in;
    t_job job_out;
    logic push;
    logic pop;
    logic empty;
    logic full;

    // The parser classifies each byte and emits a job on the last byte.
    atoc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    // The queue lets the parser keep taking bytes while a division runs.
    atoc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty),
        .o_full  (full)
    );

    // The execution unit computes the result and drives the result channel.
    atoc_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== tb/sv/ascii_two_operand_calculator_tb.sv =====
// Self-checking testbench for the two-operand ASCII calculator: table-driven and random expressions.
`timescale 1ns / 100ps

module ascii_two_operand_calculator_tb;
    import atoc_pkg::*;

    // The run stops with a failure at this cycle count.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // Characters to send after the directed table.
    localparam int unsigned RANDOM_CHARS = 1750;
    // After the last result, watch the output for a while longer so that a stray
    // result would show up.
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned REPORT_LIMIT = 10;

    // Character codes that the parser gives a meaning to.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MARK  = 8'hFF;

    // Where the expression scanner stands. Codes 6 and 7 are never entered;
    // they fall into the default branch and act like the done state.
    typedef enum logic [2:0] {
        SCAN_A_START  = 3'd0,
        SCAN_A_DIGITS = 3'd1,
        SCAN_OP_WAIT  = 3'd2,
        SCAN_B_START  = 3'd3,
        SCAN_B_DIGITS = 3'd4,
        SCAN_DONE     = 3'd5
    } t_scan;

    // One character request as it is sent. A request that carries the last
    // flag may also carry a typed-in result, which then replaces the predicted
    // one.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              pinned;
        logic [DATA_W-1:0] pin_value;
        logic              pin_status;
    } t_char_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     status;
    } t_result;

    // A row of the directed table. The character at patch_at, if any, is
    // replaced by patch_code, which is how the zero byte and bytes above 127
    // get into the table.
    typedef struct {
        string             text;
        int                patch_at;
        logic [CHAR_W-1:0] patch_code;
        bit                pinned;
        logic [DATA_W-1:0] value;
        bit                status;
    } t_sample;

    // The directed expressions. Rows whose result is obvious carry it; the rest
    // are checked against the predictor like the random part.
    t_sample samples[$] = '{
        '{"7+5",                    -1, CH_NUL,  1'b1, 32'd12,         1'b0},
        // Whitespace around the operator.
        '{"9 - 12",                 -1, CH_NUL,  1'b1, 32'hFFFF_FFFD,  1'b0},
        // Trailing characters after the second number are ignored.
        '{"6*7 z",                  -1, CH_NUL,  1'b1, 32'd42,         1'b0},
        '{"9/0",                    -1, CH_NUL,  1'b1, 32'd0,          1'b1},
        // The first operand wraps while digits are collected, leaving the most
        // negative value, which is then divided by minus one.
        '{"0x180000000/0XFFFFFFFF", -1, CH_NUL,  1'b1, 32'h8000_0000,  1'b0},
        '{"1%2",                    -1, CH_NUL,  1'b1, 32'd0,          1'b1},
        // No operator at all.
        '{"12",                     -1, CH_NUL,  1'b1, 32'd0,          1'b1},
        // No first number: the operand is zero and the byte is the operator.
        '{"+3",                     -1, CH_NUL,  1'b1, 32'd3,          1'b0},
        // A digit in operator position is taken as an unknown operator.
        '{"4 5",                    -1, CH_NUL,  1'b1, 32'd0,          1'b1},
        // No second number: the operand is zero.
        '{"8-",                     -1, CH_NUL,  1'b1, 32'd8,          1'b0},
        // A zero byte ends the expression; the digit after it is ignored.
        '{"5+03",                    2, CH_NUL,  1'b1, 32'd5,          1'b0},
        // The highest byte value, alone, as an operator.
        '{"?",                       0, CH_MARK, 1'b1, 32'd0,          1'b1},
        // Mixed-case hex digits, and a second number that stops right after 0x.
        '{"0xAb-0x",                -1, CH_NUL,  1'b0, 32'd0,          1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    atoc_char_if   char_bus ();
    atoc_result_if rsp_bus ();

    ascii_two_operand_calculator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (char_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Everything that is to be sent, built before reset is released.
    t_char_req   char_reqs[$];
    // Scratch buffer for the expression being generated.
    logic [CHAR_W-1:0] expr_text[$];
    // Results predicted for accepted expressions, oldest first.
    t_result     pending_results[$];

    int unsigned accepted_chars = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned sink_stall     = 0;
    // While calm is set, neither side idles, so the block also sees long runs
    // at full rate.
    logic        calm           = 1'b0;

    // Predictor state, the same set of registers that the block keeps.
    t_scan             scan_phase = SCAN_A_START;
    logic [DATA_W-1:0] lhs_acc    = '0;
    logic [DATA_W-1:0] rhs_acc    = '0;
    logic [CHAR_W-1:0] op_char    = CH_NUL;
    logic              in_hex     = 1'b0;
    logic              lone_zero  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit is_blank(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    // Weight of c as a digit in the current radix, or -1 if it is no digit.
    function automatic int digit_weight(input logic [CHAR_W-1:0] c, input logic hex);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (hex && c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
        if (hex && c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    // A number can only open with a decimal digit. A lone leading zero is
    // remembered so that a following x or X can switch to hex.
    function automatic bit open_number(input logic [CHAR_W-1:0] c,
                                       inout logic [DATA_W-1:0] acc);
        in_hex = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            acc       = DATA_W'(c - CH_ZERO);
            lone_zero = (c == CH_ZERO);
            return 1'b1;
        end
        lone_zero = 1'b0;
        return 1'b0;
    endfunction

    // Returns 0 when c does not belong to the number. Digits wrap modulo 2^32.
    function automatic bit extend_number(input logic [CHAR_W-1:0] c,
                                         inout logic [DATA_W-1:0] acc);
        int w;
        if (lone_zero && (c == CH_LO_X || c == CH_UP_X)) begin
            in_hex    = 1'b1;
            lone_zero = 1'b0;
            return 1'b1;
        end
        w = digit_weight(c, in_hex);
        if (w < 0) return 1'b0;
        acc       = acc * (in_hex ? 32'd16 : 32'd10) + DATA_W'(w);
        lone_zero = 1'b0;
        return 1'b1;
    endfunction

    // Any byte that is not whitespace becomes the operator, known or not.
    function automatic void take_operator(input logic [CHAR_W-1:0] c);
        if (is_blank(c)) begin
            scan_phase = SCAN_OP_WAIT;
        end else begin
            op_char    = c;
            scan_phase = SCAN_B_START;
        end
    endfunction

    function automatic void scan_byte(input logic [CHAR_W-1:0] c);
        if (c == CH_NUL) begin
            scan_phase = SCAN_DONE;
            return;
        end
        case (scan_phase)
            SCAN_A_START: begin
                if (open_number(c, lhs_acc)) scan_phase = SCAN_A_DIGITS;
                else take_operator(c);
            end
            SCAN_A_DIGITS: begin
                if (!extend_number(c, lhs_acc)) take_operator(c);
            end
            SCAN_OP_WAIT: begin
                take_operator(c);
            end
            SCAN_B_START: begin
                if (!is_blank(c)) begin
                    if (open_number(c, rhs_acc)) scan_phase = SCAN_B_DIGITS;
                    else scan_phase = SCAN_DONE;
                end
            end
            SCAN_B_DIGITS: begin
                if (!extend_number(c, rhs_acc)) scan_phase = SCAN_DONE;
            end
            default: begin
            end
        endcase
    endfunction

    // Quotients truncate toward zero; they are formed on magnitudes so that
    // the most negative value over minus one simply wraps.
    function automatic t_result evaluate_expr();
        t_result           r;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] quo;
        r.value  = '0;
        r.status = 1'b0;
        case (op_char)
            CH_PLUS:  r.value = lhs_acc + rhs_acc;
            CH_MINUS: r.value = lhs_acc - rhs_acc;
            CH_STAR:  r.value = lhs_acc * rhs_acc;
            CH_SLASH: begin
                if (rhs_acc == '0) begin
                    r.status = 1'b1;
                end else begin
                    mag_a   = lhs_acc[DATA_W-1] ? -lhs_acc : lhs_acc;
                    mag_b   = rhs_acc[DATA_W-1] ? -rhs_acc : rhs_acc;
                    quo     = mag_a / mag_b;
                    r.value = (lhs_acc[DATA_W-1] ^ rhs_acc[DATA_W-1]) ? -quo : quo;
                end
            end
            default:  r.status = 1'b1;
        endcase
        return r;
    endfunction

    function automatic void clear_scan();
        scan_phase = SCAN_A_START;
        lhs_acc    = '0;
        rhs_acc    = '0;
        op_char    = CH_NUL;
        in_hex     = 1'b0;
        lone_zero  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_char(input logic [CHAR_W-1:0] code, input logic last,
                                       input logic pinned, input logic [DATA_W-1:0] value,
                                       input logic status);
        t_char_req req;
        req.code       = code;
        req.last       = last;
        req.pinned     = pinned;
        req.pin_value  = value;
        req.pin_status = status;
        char_reqs.push_back(req);
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input int unsigned w, input bit upper);
        if (w < 10) return CH_ZERO + CHAR_W'(w);
        return (upper ? CH_UP_A : CH_LO_A) + CHAR_W'(w - 10);
    endfunction

    // Appends a number: decimal (sometimes long enough to wrap), hex with a
    // random number of digits (none at all included), eight hex digits of a
    // boundary or random value, or nothing.
    function automatic void emit_number();
        int unsigned       form;
        int unsigned       ndig;
        int unsigned       w;
        logic [DATA_W-1:0] pick;
        form = $urandom_range(0, 9);
        if (form <= 4) begin
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            repeat (ndig) expr_text.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        end else if (form <= 8) begin
            expr_text.push_back(CH_ZERO);
            expr_text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            case ($urandom_range(0, 3))
                0:       pick = 32'h8000_0000;
                1:       pick = 32'hFFFF_FFFF;
                2:       pick = 32'h7FFF_FFFF;
                default: pick = $urandom();
            endcase
            ndig = (form == 8) ? 8 : $urandom_range(0, 9);
            for (int k = 0; k < ndig; k++) begin
                w = (form == 8) ? int'(pick[31-4*k -: 4]) : $urandom_range(0, 15);
                expr_text.push_back(hex_char(w, $urandom_range(0, 1)));
            end
        end
    endfunction

    function automatic void emit_blanks();
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0:       expr_text.push_back(CH_SPACE);
                    1:       expr_text.push_back(CH_TAB);
                    2:       expr_text.push_back(CH_CR);
                    default: expr_text.push_back(CH_LF);
                endcase
            end
        end
    endfunction

    function automatic void emit_operator();
        if ($urandom_range(0, 99) < 88) begin
            case ($urandom_range(0, 3))
                0:       expr_text.push_back(CH_PLUS);
                1:       expr_text.push_back(CH_MINUS);
                2:       expr_text.push_back(CH_STAR);
                default: expr_text.push_back(CH_SLASH);
            endcase
        end else begin
            expr_text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
    endfunction

    // Most expressions are well formed with random content. The rest are pure
    // noise, cut short, or carry one byte overwritten by a random byte or by
    // the zero byte.
    function automatic void add_expression();
        int unsigned style;
        int unsigned keep;
        expr_text.delete();
        style = $urandom_range(0, 99);
        if (style < 8) begin
            repeat ($urandom_range(1, 8)) expr_text.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
            emit_number();
            emit_blanks();
            emit_operator();
            emit_blanks();
            emit_number();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) expr_text.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            if (style < 16 && expr_text.size() > 1) begin
                keep = $urandom_range(1, expr_text.size() - 1);
                while (expr_text.size() > keep) void'(expr_text.pop_back());
            end else if (style < 24) begin
                expr_text[$urandom_range(0, expr_text.size() - 1)] =
                    CHAR_W'($urandom_range(0, 255));
            end else if (style < 28) begin
                expr_text[$urandom_range(0, expr_text.size() - 1)] = CH_NUL;
            end
        end
        foreach (expr_text[k]) begin
            queue_char(expr_text[k], k == expr_text.size() - 1, 1'b0, '0, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void log_fault(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Both handshakes are sampled at the rising edge, before any register of
    // the block or of the testbench takes its new value. An accepted character
    // request advances the predictor; a last flag turns the scanner state into
    // an expected result. An accepted result request is compared field by field
    // with the oldest expected result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (char_bus.valid && char_bus.ready) begin
                scan_byte(char_bus.char_code);
                if (char_bus.last) begin
                    want = evaluate_expr();
                    if (char_reqs[accepted_chars].pinned) begin
                        want.value  = char_reqs[accepted_chars].pin_value;
                        want.status = char_reqs[accepted_chars].pin_status;
                    end
                    pending_results.push_back(want);
                    clear_scan();
                end
                accepted_chars++;
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_results.size() == 0) begin
                    log_fault($sformatf("result value %h status %0d with none expected",
                                        rsp_bus.value, rsp_bus.status));
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_bus.value !== want.value || rsp_bus.status !== want.status) begin
                        log_fault($sformatf("value exp %h got %h, status exp %0d got %0d",
                                            want.value, rsp_bus.value,
                                            want.status, rsp_bus.status));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (sink_stall == 0 && !calm && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
        if (sink_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            sink_stall = sink_stall - 1;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // Cycle count, the calm windows and the watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 4) == 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Character side: reset, stimulus, end of run
    // ------------------------------------------------------------------

    initial begin
        logic [CHAR_W-1:0] code;
        int unsigned       directed_chars;
        int unsigned       gap;
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = CH_NUL;
        char_bus.last      = 1'b0;
        rsp_bus.ready      = 1'b0;

        // Walk the directed table. Only the final character of a row carries the
        // last flag; each character carries the row's typed-in result, if any.
        foreach (samples[i]) begin
            for (int j = 0; j < samples[i].text.len(); j++) begin
                code = (j == samples[i].patch_at) ? samples[i].patch_code
                                                  : CHAR_W'(samples[i].text[j]);
                queue_char(code, j == samples[i].text.len() - 1, samples[i].pinned,
                           samples[i].value, samples[i].status);
            end
        end
        directed_chars = char_reqs.size();
        while (char_reqs.size() < directed_chars + RANDOM_CHARS) add_expression();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Send each request, with a random gap in front of it, and hold it
        // until the block takes it. Valid is lowered only when a gap follows.
        foreach (char_reqs[k]) begin
            gap = calm ? 0 : pick_gap();
            if (gap != 0) begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            char_bus.valid     <= 1'b1;
            char_bus.char_code <= char_reqs[k].code;
            char_bus.last      <= char_reqs[k].last;
            @(posedge i_clk);
            while (!char_bus.ready) @(posedge i_clk);
        end
        char_bus.valid <= 1'b0;

        // Wait so that the monitor has booked the final request.
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
